@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dwmd_pkg.sv @@
package dwmd_pkg;

  // Fixed field widths.
  localparam int SYM_W      = 8;
  localparam int POS_OUT_W  = 16;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int SYM_DEPTH  = 1 << SYM_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 1'b1;

  // Reset values of the window lengths.
  localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = 5'd4;
  localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = 5'd14;

  // One result transaction.
  typedef struct packed {
    logic [POS_OUT_W-1:0] position;
    logic                 short_marker;
    logic                 long_marker;
    logic                 both_found;
  } result_t;

endpackage

@@ sv/dwmd_last_pos_ram.sv @@
// Last-seen position of every symbol value: one write port, one registered read port.
module dwmd_last_pos_ram #(
  parameter int DATA_W = 5
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [dwmd_pkg::SYM_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0]           wr_data,
  input  logic                        rd_en,
  input  logic [dwmd_pkg::SYM_W-1:0]  rd_addr,
  output logic [DATA_W-1:0]           rd_data
);

  logic [DATA_W-1:0] mem [dwmd_pkg::SYM_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/dwmd_core.sv @@
// Run-length tracker: combines the last-seen position of the symbol with the
// short history to keep the length of the longest distinct suffix.
module dwmd_core #(
  parameter int WINDOW_MAX = 16,
  parameter int COUNT_BITS = 16,
  parameter int POS_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [dwmd_pkg::SYM_W-1:0]    sym,
  input  logic                          restart,
  input  logic [POS_W-1:0]              rd_pos,
  input  logic [dwmd_pkg::CFG_W-1:0]    short_cfg,
  input  logic [dwmd_pkg::CFG_W-1:0]    long_cfg,
  output logic                          wr_en,
  output logic [dwmd_pkg::SYM_W-1:0]    wr_addr,
  output logic [POS_W-1:0]              wr_data,
  output dwmd_pkg::result_t             result
);

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int RUN_W = $clog2(WINDOW_MAX + 1);
  localparam logic [POS_W-1:0]      WIN_P     = POS_W'(WINDOW_MAX);
  localparam logic [RUN_W-1:0]      RUN_MAX   = RUN_W'(WINDOW_MAX);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [dwmd_pkg::SYM_W-1:0] history [WINDOW_MAX];
  logic [POS_W-1:0]           pos_cnt;
  logic [RUN_W-1:0]           run;
  logic [COUNT_BITS-1:0]      byte_count;
  logic                       short_seen;
  logic                       long_seen;
  logic                       fwd_valid;
  logic [dwmd_pkg::SYM_W-1:0] fwd_sym;
  logic [POS_W-1:0]           fwd_pos;

  logic [POS_W-1:0]      last_pos;
  logic [POS_W-1:0]      gap;
  logic [IDX_W-1:0]      hist_idx;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [RUN_W-1:0]      run_base;
  logic [RUN_W-1:0]      run_inc;
  logic [RUN_W-1:0]      run_next;
  logic                  dup_hit;
  logic                  short_base;
  logic                  long_base;
  logic [RUN_W-1:0]      short_len;
  logic [RUN_W-1:0]      long_len;
  logic                  short_hit;
  logic                  long_hit;

  // The previous write may not have reached the read data yet, so forward it.
  assign last_pos = (fwd_valid && (fwd_sym == sym)) ? fwd_pos : rd_pos;
  assign gap      = pos_cnt - last_pos;
  assign hist_idx = IDX_W'(gap - POS_W'(1));

  // A restart clears the stream state before this byte is taken.
  assign count_base = restart ? '0 : byte_count;
  assign run_base   = restart ? '0 : run;
  assign short_base = restart ? 1'b0 : short_seen;
  assign long_base  = restart ? 1'b0 : long_seen;

  // A stored position is only trusted when the history confirms it and it lies
  // within the current stream.
  assign dup_hit = (gap != '0) && (gap <= WIN_P) &&
                   (count_base >= COUNT_BITS'(gap)) && (history[hist_idx] == sym);

  assign run_inc  = (run_base == RUN_MAX) ? run_base : run_base + RUN_W'(1);
  assign run_next = (dup_hit && (RUN_W'(gap) < run_inc)) ? RUN_W'(gap) : run_inc;

  assign byte_count_next = (count_base == COUNT_MAX) ? count_base
                                                     : count_base + COUNT_BITS'(1);

  // Clamp the window lengths to the range 1 to WINDOW_MAX.
  always_comb begin
    if (short_cfg == '0) begin
      short_len = RUN_W'(1);
    end else if (int'(short_cfg) > WINDOW_MAX) begin
      short_len = RUN_MAX;
    end else begin
      short_len = RUN_W'(short_cfg);
    end
    if (long_cfg == '0) begin
      long_len = RUN_W'(1);
    end else if (int'(long_cfg) > WINDOW_MAX) begin
      long_len = RUN_MAX;
    end else begin
      long_len = RUN_W'(long_cfg);
    end
  end

  // A window is distinct when the distinct suffix covers it.
  assign short_hit = !short_base && (byte_count_next >= COUNT_BITS'(short_len)) &&
                     (run_next >= short_len);
  assign long_hit  = !long_base && (byte_count_next >= COUNT_BITS'(long_len)) &&
                     (run_next >= long_len);

  // Position field saturates at its own maximum.
  generate
    if (COUNT_BITS > dwmd_pkg::POS_OUT_W) begin : g_pos_sat
      assign result.position =
        (byte_count_next > COUNT_BITS'({dwmd_pkg::POS_OUT_W{1'b1}})) ?
        {dwmd_pkg::POS_OUT_W{1'b1}} : byte_count_next[dwmd_pkg::POS_OUT_W-1:0];
    end else begin : g_pos_ext
      assign result.position = dwmd_pkg::POS_OUT_W'(byte_count_next);
    end
  endgenerate

  assign result.short_marker = short_hit;
  assign result.long_marker  = long_hit;
  assign result.both_found   = (short_base || short_hit) && (long_base || long_hit);

  // Record the position of this symbol.
  assign wr_en   = advance;
  assign wr_addr = sym;
  assign wr_data = pos_cnt;

  // History shift line.
  always_ff @(posedge clk) begin
    if (advance) begin
      history[0] <= sym;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  // Stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt    <= '0;
      run        <= '0;
      byte_count <= '0;
      short_seen <= 1'b0;
      long_seen  <= 1'b0;
      fwd_valid  <= 1'b0;
    end else if (advance) begin
      pos_cnt    <= pos_cnt + POS_W'(1);
      run        <= run_next;
      byte_count <= byte_count_next;
      short_seen <= short_base || short_hit;
      long_seen  <= long_base || long_hit;
      fwd_valid  <= 1'b1;
    end
  end

  // Forwarding copy of the last write.
  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_sym <= sym;
      fwd_pos <= pos_cnt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_short_sticky, short_seen && !(advance && restart), short_seen, "short flag lost")
  `ASSERT_NEXT(a_long_sticky, long_seen && !(advance && restart), long_seen, "long flag lost")
  `ASSERT_CLK(a_run_in_stream, (run == '0) || (byte_count != '0), "run outside a stream")
  `ASSERT_CLK(a_run_bound, run <= RUN_MAX, "run beyond window")

endmodule

@@ sv/distinct_window_marker_detect.sv @@
// Distinct-window marker detector.
// Input channel (in_valid/in_ready) carries one byte per transaction in symbol,
// with restart set on the first byte of a new stream. Every input transaction
// produces exactly one output transaction (out_valid/out_ready) carrying the
// saturating byte position, the one-shot short and long markers and both_found.
// Window lengths are written through cfg_write/cfg_index/cfg_data while idle.
// The byte and its last-position read are registered in the read stage when the
// byte is accepted, and the output register loads the result when the read
// stage advances into it. Throughput: one byte per cycle while the receiver
// takes results; the read-modify-write of the last-position memory is
// forwarded, so consecutive bytes never wait on each other.
// Reset clears the stream count, flags and pipeline, and restores window
// lengths of 4 and 14. It then starts a clearing pass that zeroes the 256
// last-position entries one per cycle, and in_ready stays low for those cycles.
// When the receiver stalls the result is held in the output register, one more
// byte may sit in the read stage, and in_ready then falls until space returns.
module distinct_window_marker_detect #(
  parameter int WINDOW_MAX = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dwmd_pkg::SYM_W-1:0]         symbol,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dwmd_pkg::POS_OUT_W-1:0]     position,
  output logic                               short_marker,
  output logic                               long_marker,
  output logic                               both_found,
  input  logic                               cfg_write,
  input  logic [dwmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwmd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int POS_W = $clog2(WINDOW_MAX) + 1;
  localparam int CLR_W = dwmd_pkg::SYM_W;

  logic [dwmd_pkg::CFG_W-1:0] short_window;
  logic [dwmd_pkg::CFG_W-1:0] long_window;
  logic                       s1_valid;
  logic [dwmd_pkg::SYM_W-1:0] s1_sym;
  logic                       s1_restart;
  logic                       in_fire;
  logic                       advance;
  logic [POS_W-1:0]           rd_pos;
  logic                       wr_en;
  logic [dwmd_pkg::SYM_W-1:0] wr_addr;
  logic [POS_W-1:0]           wr_data;
  logic                       clr_busy;
  logic [CLR_W-1:0]           clr_addr;
  logic                       ram_wr_en;
  logic [dwmd_pkg::SYM_W-1:0] ram_wr_addr;
  logic [POS_W-1:0]           ram_wr_data;
  dwmd_pkg::result_t          core_res;
  dwmd_pkg::result_t          out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= dwmd_pkg::SHORT_WINDOW_RST;
      long_window  <= dwmd_pkg::LONG_WINDOW_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dwmd_pkg::CFG_SHORT_WINDOW: short_window <= cfg_data;
        dwmd_pkg::CFG_LONG_WINDOW:  long_window  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass: after reset every last-position entry is zeroed, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + CLR_W'(1);
      if (clr_addr == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Handshake: the read stage moves on whenever the output register has room.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_busy && (!s1_valid || advance);
  assign in_fire  = in_valid && in_ready;

  // Read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sym     <= symbol;
      s1_restart <= restart;
    end
  end

  // The clearing pass owns the write port until it is done.
  assign ram_wr_en   = clr_busy || wr_en;
  assign ram_wr_addr = clr_busy ? clr_addr : wr_addr;
  assign ram_wr_data = clr_busy ? '0 : wr_data;

  dwmd_last_pos_ram #(
    .DATA_W (POS_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (symbol),
    .rd_data (rd_pos)
  );

  dwmd_core #(
    .WINDOW_MAX (WINDOW_MAX),
    .COUNT_BITS (COUNT_BITS),
    .POS_W      (POS_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .sym       (s1_sym),
    .restart   (s1_restart),
    .rd_pos    (rd_pos),
    .short_cfg (short_window),
    .long_cfg  (long_window),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .result    (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign position     = out_res.position;
  assign short_marker = out_res.short_marker;
  assign long_marker  = out_res.long_marker;
  assign both_found   = out_res.both_found;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1_sym), "read stage lost")
  `ASSERT_CLK(a_no_overwrite, !(advance && out_valid && !out_ready), "result overwritten")
  `ASSERT_CLK(a_clear_quiet, !(clr_busy && (s1_valid || wr_en)), "traffic during clearing")

endmodule
